>>> rtl/nsr_pkg.sv
// shared types and constants for the newton square root block
`default_nettype none
package nsr_pkg;

  localparam int FRAC_BITS = 32;
  localparam int XW        = 64;
  localparam int HALF      = XW / 2;
  localparam int WW        = 2 * XW;
  localparam int STEPW     = 6;
  localparam int TOLW      = 32;
  localparam int CNTW      = 6;
  localparam int DIV_STEPS = XW;
  localparam int CFGW      = 2;

  localparam logic [XW-1:0]    ONE           = XW'(1) << FRAC_BITS;
  localparam logic [STEPW-1:0] MAX_STEPS_RST = 6'd50;
  localparam logic [TOLW-1:0]  TOL_RST       = 32'd1;

  // configuration register indexes
  localparam logic [CFGW-1:0] CFG_MAX_STEPS = 2'd0;
  localparam logic [CFGW-1:0] CFG_TOLERANCE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_DIFF,
    ST_CMP,
    ST_DECIDE,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

  // which 32x32 partial product of x*x to form
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_LH,
    MUL_HH
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     sq_clr;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     diff_en;
    logic     chk_en;
    logic     div_init;
    logic     div_step;
    logic     upd;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic miss;
    logic at_limit;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/nsr_dp.sv
// datapath: estimate, squaring by partial products, error check, radix-2 divider
`default_nettype none
module nsr_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire nsr_pkg::cmd_t                  cmd,
  output nsr_pkg::sts_t                       sts,
  input  wire logic [nsr_pkg::XW-1:0]         in_radicand,
  input  wire logic                           cfg_we,
  input  wire logic [nsr_pkg::CFGW-1:0]       cfg_index,
  input  wire logic [nsr_pkg::TOLW-1:0]       cfg_data,
  output logic      [nsr_pkg::XW-1:0]         root,
  output logic      [nsr_pkg::STEPW-1:0]      steps_used,
  output logic                                converged
);

  logic [nsr_pkg::STEPW-1:0] max_steps_r;
  logic [nsr_pkg::TOLW-1:0]  tol_r;

  logic [nsr_pkg::XW-1:0]    b_r;
  logic [nsr_pkg::XW-1:0]    x_r;
  logic [nsr_pkg::STEPW-1:0] steps_r;
  logic [nsr_pkg::WW-1:0]    acc_r;
  logic [nsr_pkg::XW-1:0]    prod_r;
  nsr_pkg::mul_sel_t         psel_r;
  logic [nsr_pkg::WW-1:0]    diff_r;
  logic                      miss_r;
  logic [nsr_pkg::XW-1:0]    rem_r;
  logic [nsr_pkg::XW-1:0]    num_r;
  logic [nsr_pkg::XW-1:0]    quo_r;
  logic                      sat_r;
  logic [nsr_pkg::XW-1:0]    root_r;
  logic [nsr_pkg::STEPW-1:0] steps_out_r;
  logic                      conv_r;

  logic [nsr_pkg::WW-1:0]    target;
  logic [nsr_pkg::WW-1:0]    tol_w;
  logic [nsr_pkg::HALF-1:0]  mul_a;
  logic [nsr_pkg::HALF-1:0]  mul_b;
  logic [nsr_pkg::XW-1:0]    prod_nxt;
  logic [nsr_pkg::WW-1:0]    addend;
  logic [nsr_pkg::XW:0]      trial;
  logic                      trial_ge;
  logic [nsr_pkg::XW:0]      trial_diff;
  logic [nsr_pkg::XW-1:0]    quo_sel;
  logic [nsr_pkg::XW:0]      sum;

  assign target = nsr_pkg::WW'(b_r) << nsr_pkg::FRAC_BITS;
  assign tol_w  = nsr_pkg::WW'(tol_r) << nsr_pkg::FRAC_BITS;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= nsr_pkg::MAX_STEPS_RST;
      tol_r       <= nsr_pkg::TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsr_pkg::CFG_MAX_STEPS: max_steps_r <= cfg_data[nsr_pkg::STEPW-1:0];
        nsr_pkg::CFG_TOLERANCE: tol_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // one 32x32 multiplier, shared over the three partial products of x*x
  always_comb begin
    mul_a = x_r[nsr_pkg::HALF-1:0];
    mul_b = x_r[nsr_pkg::HALF-1:0];
    case (cmd.mul_sel)
      nsr_pkg::MUL_LH: mul_b = x_r[nsr_pkg::XW-1:nsr_pkg::HALF];
      nsr_pkg::MUL_HH: begin
        mul_a = x_r[nsr_pkg::XW-1:nsr_pkg::HALF];
        mul_b = x_r[nsr_pkg::XW-1:nsr_pkg::HALF];
      end
      default: ;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // cross term counts twice, so it lands one bit above its weight
  always_comb begin
    case (psel_r)
      nsr_pkg::MUL_LL: addend = nsr_pkg::WW'(prod_r);
      nsr_pkg::MUL_LH: addend = nsr_pkg::WW'(prod_r) << (nsr_pkg::HALF + 1);
      nsr_pkg::MUL_HH: addend = nsr_pkg::WW'(prod_r) << nsr_pkg::XW;
      default:         addend = '0;
    endcase
  end

  // restoring divide step; the shifted-out top bit makes the trial 65 bits
  assign trial      = {rem_r, num_r[nsr_pkg::XW-1]};
  assign trial_ge   = trial >= {1'b0, x_r};
  assign trial_diff = trial - {1'b0, x_r};
  assign quo_sel    = sat_r ? '1 : quo_r;
  assign sum        = {1'b0, quo_sel} + {1'b0, x_r};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    psel_r <= cmd.mul_sel;
    if (cmd.load) begin
      b_r     <= in_radicand;
      x_r     <= nsr_pkg::ONE;
      steps_r <= '0;
    end else if (cmd.upd) begin
      x_r     <= sum[nsr_pkg::XW:1];
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.sq_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + addend;
    end
    if (cmd.diff_en) begin
      diff_r <= (acc_r >= target) ? (acc_r - target) : (target - acc_r);
    end
    if (cmd.chk_en) begin
      miss_r <= diff_r > tol_w;
    end
    if (cmd.div_init) begin
      rem_r <= target[nsr_pkg::WW-1:nsr_pkg::XW];
      num_r <= target[nsr_pkg::XW-1:0];
      quo_r <= '0;
      sat_r <= (x_r == '0) || (target[nsr_pkg::WW-1:nsr_pkg::XW] >= x_r);
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_diff[nsr_pkg::XW-1:0] : trial[nsr_pkg::XW-1:0];
      num_r <= {num_r[nsr_pkg::XW-2:0], 1'b0};
      quo_r <= {quo_r[nsr_pkg::XW-2:0], trial_ge};
    end
    if (cmd.out_load) begin
      root_r      <= x_r;
      steps_out_r <= steps_r;
      conv_r      <= !miss_r;
    end
  end

  assign sts.miss     = miss_r;
  assign sts.at_limit = steps_r >= max_steps_r;

  assign root       = root_r;
  assign steps_used = steps_out_r;
  assign converged  = conv_r;

  a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (x_r == nsr_pkg::ONE && steps_r == '0))
    else $error("estimate not reset to one on load");

  a_upd_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> steps_r == nsr_pkg::STEPW'($past(steps_r) + 1'b1))
    else $error("step count not advanced on update");

  a_out_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> converged == !$past(miss_r))
    else $error("converged flag does not follow last check");

endmodule
`default_nettype wire

>>> rtl/nsr_ctrl.sv
// controller state machine sequencing squaring, check, divide and update
`default_nettype none
module nsr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire nsr_pkg::sts_t sts,
  output nsr_pkg::cmd_t      cmd
);

  nsr_pkg::state_t           state_r, state_nxt;
  logic [nsr_pkg::CNTW-1:0]  cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      nsr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = nsr_pkg::ST_SQ;
        end
      end
      nsr_pkg::ST_SQ: begin
        // multiply result is registered ahead of the accumulate
        cmd.sq_clr = (cnt_r == '0);
        cmd.acc_en = (cnt_r != '0);
        case (cnt_r[1:0])
          2'd0:    cmd.mul_sel = nsr_pkg::MUL_LL;
          2'd1:    cmd.mul_sel = nsr_pkg::MUL_LH;
          2'd2:    cmd.mul_sel = nsr_pkg::MUL_HH;
          default: cmd.mul_sel = nsr_pkg::MUL_NONE;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == nsr_pkg::CNTW'(3)) begin
          cnt_nxt   = '0;
          state_nxt = nsr_pkg::ST_DIFF;
        end
      end
      nsr_pkg::ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = nsr_pkg::ST_CMP;
      end
      nsr_pkg::ST_CMP: begin
        cmd.chk_en = 1'b1;
        state_nxt  = nsr_pkg::ST_DECIDE;
      end
      nsr_pkg::ST_DECIDE: begin
        if (sts.miss && !sts.at_limit) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = nsr_pkg::ST_DIV;
        end else begin
          state_nxt = nsr_pkg::ST_FIN;
        end
      end
      nsr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == nsr_pkg::CNTW'(nsr_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = nsr_pkg::ST_UPD;
        end
      end
      nsr_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = nsr_pkg::ST_SQ;
      end
      nsr_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = nsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  a_upd_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nsr_pkg::ST_UPD |-> $past(state_r) == nsr_pkg::ST_DIV)
    else $error("update entered without a finished divide");

  a_limit_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nsr_pkg::ST_DECIDE && sts.at_limit) |=> state_r == nsr_pkg::ST_FIN)
    else $error("iteration continued past the step limit");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == nsr_pkg::ST_SQ && !in_tready))
    else $error("accepted transfer did not start the squaring");

endmodule
`default_nettype wire

>>> rtl/newton_square_root.sv
// Each Newton step squares the estimate, checks the error, then divides in the one-bit-per-cycle divider and updates.
// One item in flight; the next is taken once the result sits in the output register.
// Reset (rst_n low, synchronous) idles the block and sets max_steps 50, tolerance 1.
`default_nettype none
module newton_square_root (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] radicand
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [63:0] root, [69:64] steps_used, [71:70] zero
  output logic             out_tuser,  // [0] converged
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  nsr_pkg::cmd_t                 cmd;
  nsr_pkg::sts_t                 sts;
  logic [nsr_pkg::XW-1:0]        root;
  logic [nsr_pkg::STEPW-1:0]     steps_used;
  logic                          converged;

  assign cfg_ready = 1'b1;

  nsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nsr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_radicand (in_tdata),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .root        (root),
    .steps_used  (steps_used),
    .converged   (converged)
  );

  assign out_tdata = {2'b00, steps_used, root};
  assign out_tuser = converged;

endmodule
`default_nettype wire

>>> bench/newton_square_root_check.sv
// checker for newton_square_root: predicts each root from the live limits and compares results
`timescale 1ns / 100ps
module newton_square_root_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [nsr_pkg::XW-1:0]      in_tdata,   // [63:0] radicand
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [71:0]                 out_tdata,  // [63:0] root, [69:64] steps_used, [71:70] zero
  input  logic                        out_tuser,  // [0] converged
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [nsr_pkg::CFGW-1:0]    cfg_index,
  input  logic [31:0]                 cfg_data,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic [nsr_pkg::XW-1:0]    root;
    logic [nsr_pkg::STEPW-1:0] steps;
    logic                      conv;
  } root_result_t;

  logic [nsr_pkg::STEPW-1:0] steps_cap;
  logic [nsr_pkg::TOLW-1:0]  tol_lsb;
  root_result_t              roots_due[$];
  root_result_t              want;

  // newton iteration from 1.0, exact 128-bit error test, saturating quotient
  function automatic root_result_t predict_root(input logic [nsr_pkg::XW-1:0] b,
                                                input logic [nsr_pkg::STEPW-1:0] cap,
                                                input logic [nsr_pkg::TOLW-1:0] tol);
    logic [nsr_pkg::WW-1:0]    target;
    logic [nsr_pkg::WW-1:0]    tol_w;
    logic [nsr_pkg::WW-1:0]    quo;
    logic [nsr_pkg::WW-1:0]    sq;
    logic [nsr_pkg::WW-1:0]    gap;
    logic [nsr_pkg::XW-1:0]    x;
    logic [nsr_pkg::XW-1:0]    q;
    logic [nsr_pkg::XW:0]      s;
    logic [nsr_pkg::STEPW-1:0] n;
    logic                      miss;
    root_result_t              r;
    target = {{nsr_pkg::XW{1'b0}}, b} << nsr_pkg::FRAC_BITS;
    tol_w  = {{(nsr_pkg::WW-nsr_pkg::TOLW){1'b0}}, tol} << nsr_pkg::FRAC_BITS;
    x      = nsr_pkg::ONE;
    n      = '0;
    while (1) begin
      sq   = {{nsr_pkg::XW{1'b0}}, x} * {{nsr_pkg::XW{1'b0}}, x};
      gap  = (sq > target) ? sq - target : target - sq;
      miss = gap > tol_w;
      if (!miss || n >= cap) break;
      if (x == '0) begin
        q = '1;
      end else begin
        quo = target / {{nsr_pkg::XW{1'b0}}, x};
        q   = (quo[nsr_pkg::WW-1:nsr_pkg::XW] != '0) ? '1 : quo[nsr_pkg::XW-1:0];
      end
      s = {1'b0, q} + {1'b0, x};
      x = s[nsr_pkg::XW:1];
      n = n + 1'b1;
    end
    r.root  = x;
    r.steps = n;
    r.conv  = !miss;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      steps_cap  = nsr_pkg::MAX_STEPS_RST;
      tol_lsb    = nsr_pkg::TOL_RST;
      fail_count = 0;
      roots_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (roots_due.size() == 0) begin
          $display("%0t: result with nothing expected: root %h steps %0d converged %b",
                   $time, out_tdata[63:0], out_tdata[69:64], out_tuser);
          fail_count++;
        end else begin
          want = roots_due.pop_front();
          if (out_tdata[63:0] !== want.root) begin
            $display("%0t: root mismatch: expected %h, got %h",
                     $time, want.root, out_tdata[63:0]);
            fail_count++;
          end
          if (out_tdata[69:64] !== want.steps) begin
            $display("%0t: steps_used mismatch: expected %0d, got %0d",
                     $time, want.steps, out_tdata[69:64]);
            fail_count++;
          end
          if (out_tuser !== want.conv) begin
            $display("%0t: converged mismatch: expected %b, got %b",
                     $time, want.conv, out_tuser);
            fail_count++;
          end
          if (out_tdata[71:70] !== 2'b00) begin
            $display("%0t: tdata padding mismatch: expected 00, got %b",
                     $time, out_tdata[71:70]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        roots_due.push_back(predict_root(in_tdata, steps_cap, tol_lsb));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nsr_pkg::CFG_MAX_STEPS: steps_cap = cfg_data[nsr_pkg::STEPW-1:0];
          nsr_pkg::CFG_TOLERANCE: tol_lsb = cfg_data[nsr_pkg::TOLW-1:0];
          default: ;
        endcase
      end
    end
    pending = roots_due.size();
  end

endmodule

>>> bench/newton_square_root_test.sv
// top of the newton_square_root testbench: clock, reset, stimulus, back pressure and verdict
`timescale 1ns / 100ps
module newton_square_root_test;

  localparam int HOLD_CYCLES = 6000;
  localparam int QUIET_LIMIT = 40000;
  localparam int SETTLE      = 10;

  logic                        clk;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [nsr_pkg::XW-1:0]      in_tdata   = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [71:0]                 out_tdata;
  logic                        out_tuser;
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  logic [nsr_pkg::CFGW-1:0]    cfg_index  = '0;
  logic [31:0]                 cfg_data   = '0;

  int   fail_count;
  int   pending;
  int   send_idle  = 29;
  int   recv_idle  = 55;
  logic hold_req   = 1'b0;
  logic hold_done  = 1'b0;
  int   hold_left  = 0;
  int   quiet      = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  newton_square_root u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  newton_square_root_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle);
    end
  end

  // counts cycles without any transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("newton_square_root_test: FAIL");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic push_radicand(input logic [nsr_pkg::XW-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      in_tdata  = {$urandom, $urandom};
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [nsr_pkg::CFGW-1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = $urandom;
  endtask

  task automatic set_limits(input logic [nsr_pkg::STEPW-1:0] steps,
                            input logic [nsr_pkg::TOLW-1:0] tol);
    drain();
    write_reg(nsr_pkg::CFG_MAX_STEPS, 32'(steps));
    write_reg(nsr_pkg::CFG_TOLERANCE, tol);
  endtask

  function automatic logic [nsr_pkg::XW-1:0] random_radicand();
    logic [31:0] k;
    k = $urandom;
    case ($urandom_range(7))
      0: return {32'd0, k} * {32'd0, k};  // exact square, root is k << 16
      1: return 64'(k[3:0]);
      2: return '1 - 64'(k[7:0]);
      default: return {$urandom, k} >> $urandom_range(63);
    endcase
  endfunction

  task automatic random_block(input int count);
    logic [nsr_pkg::STEPW-1:0] steps;
    logic [nsr_pkg::TOLW-1:0]  tol;
    case ($urandom_range(9))
      0: steps = '0;
      1: steps = '1;
      default: steps = nsr_pkg::STEPW'($urandom_range(50, 1));
    endcase
    case ($urandom_range(9))
      0: tol = '0;
      1: tol = '1;
      2, 3, 4: tol = 32'd1;
      default: tol = $urandom >> $urandom_range(31);
    endcase
    set_limits(steps, tol);
    repeat (count) push_radicand(random_radicand());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset limits: 50 steps, tolerance one lsb
    push_radicand(64'h0);
    push_radicand(64'h1);
    push_radicand(nsr_pkg::ONE);
    push_radicand(64'h0000_0004_0000_0000);
    push_radicand(64'h0000_0009_0000_0000);
    push_radicand(64'h0000_0002_0000_0000);
    push_radicand(64'hFFFF_FFFF_FFFF_FFFF);
    push_radicand(64'h8000_0000_0000_0000);
    push_radicand(64'h0000_0000_FFFF_FFFF);
    push_radicand(64'h1234_5678_9ABC_DEF0);
    push_radicand(64'hFFFF_FFFE_0000_0001);

    // no steps allowed: root stays 1.0
    set_limits(6'd0, 32'd1);
    push_radicand(nsr_pkg::ONE);
    push_radicand(64'h0);
    push_radicand(64'hFFFF_FFFF_FFFF_FFFF);

    // zero tolerance: only exact squares converge
    set_limits(6'd63, 32'd0);
    push_radicand(64'h0);
    push_radicand(nsr_pkg::ONE);
    push_radicand(64'h0000_0009_0000_0000);
    push_radicand(64'h0000_0002_0000_0000);
    push_radicand(64'h1);

    // widest tolerance
    set_limits(6'd20, 32'hFFFF_FFFF);
    push_radicand(64'h0);
    push_radicand(64'hFFFF_FFFF_FFFF_FFFF);
    push_radicand(64'h0000_0100_0000_0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 29;
          recv_idle = 55;
        end
        1: begin
          send_idle = 55;
          recv_idle = 29;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (phase == 2) begin
        // short items so the block backs up while the result side holds off
        set_limits(6'd6, 32'd1);
        hold_req = 1'b1;
        repeat (8) push_radicand(random_radicand());
      end
      random_block(25);
      random_block(25);
    end

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("newton_square_root_test: PASS");
    end else begin
      $display("newton_square_root_test: FAIL");
    end
    $finish;
  end

endmodule
